### hdl/gbi_pkg.sv
// Package for the grid bilinear interpolator: sizes, status codes and the
// command record passed from the front end to the back end. No dependencies.
package gbi_pkg;
  localparam int MaxRows = 256;
  localparam int MaxCols = 512;
  localparam int MaxLayers = 4;
  localparam int RowW = 8;
  localparam int ColW = 9;
  localparam int LayW = 2;
  localparam int AddrW = LayW + RowW + ColW;
  localparam int SampleW = 32;
  localparam int QOne = 65536;
  localparam int QMax = 1114112; // QOne + 16.0 in Q16

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OUT = 2'd2;

  localparam logic [2:0] REG_NORTH = 3'd0;
  localparam logic [2:0] REG_WEST = 3'd1;
  localparam logic [2:0] REG_RSP = 3'd2;
  localparam logic [2:0] REG_CSP = 3'd3;
  localparam logic [2:0] REG_ROWS = 3'd4;
  localparam logic [2:0] REG_COLS = 3'd5;
  localparam logic [2:0] REG_LAYS = 3'd6;

  typedef struct packed {
    logic func;
    logic [LayW-1:0] load_layer;
    logic [RowW-1:0] load_row;
    logic [ColW-1:0] load_col;
    logic signed [SampleW-1:0] sample;
    logic signed [23:0] lat;
    logic signed [24:0] lon;
  } cmd_t;

  typedef struct packed {
    logic signed [23:0] north_edge;
    logic signed [24:0] west_edge;
    logic [23:0] row_spacing;
    logic [23:0] col_spacing;
    logic [8:0] rows_used;
    logic [9:0] cols_used;
    logic [2:0] layers_used;
  } cfg_t;
endpackage

### hdl/grid_bilinear_interpolator.sv
// Top level of the grid bilinear interpolator.
// Depends on gbi_pkg, gbi_queue, gbi_engine.
//
// Input channel (valid/stall): func 0 loads one sample into the grid
// memory, func 1 queries at (lat, lon). Loads give no result; a query gives
// layers_used results (clamped to 1..4), one per layer, last flagged by last.
// A two-entry command queue sits between the input port and the engine,
// so input keeps flowing while a result waits on a stalled output.
// Sequencing: a load is written to the grid memory when the engine takes it.
// Every division runs on the shared divider; a query runs two coordinate
// divisions, two factor divisions per corner in the grid and, when the status
// is OK and the weight sum is nonzero, one rounding division per layer.
// Throughput: one query at a time; the queue takes one transaction a cycle
// until full. Output holds while stall is high; the engine waits for it.
// Configuration writes (cfg_valid/cfg_ready) are taken at any time and must
// only be made while the block is idle. Synchronous reset restores the
// register defaults; grid contents are undefined until loaded.
module grid_bilinear_interpolator (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic func,
  input  logic [1:0] load_layer,
  input  logic [7:0] load_row,
  input  logic [8:0] load_col,
  input  logic signed [31:0] sample,
  input  logic signed [23:0] lat,
  input  logic signed [24:0] lon,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] layer,
  output logic signed [31:0] value,
  output logic last,
  output logic [1:0] status,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import gbi_pkg::*;
  cfg_t cfg;
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_take;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.north_edge <= 24'sd5898240;
      cfg.west_edge <= -25'sd11796480;
      cfg.row_spacing <= 24'd65536;
      cfg.col_spacing <= 24'd65536;
      cfg.rows_used <= 9'd181;
      cfg.cols_used <= 10'd360;
      cfg.layers_used <= 3'd4;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NORTH: cfg.north_edge <= cfg_data[23:0];
        REG_WEST: cfg.west_edge <= cfg_data[24:0];
        REG_RSP: cfg.row_spacing <= cfg_data[23:0];
        REG_CSP: cfg.col_spacing <= cfg_data[23:0];
        REG_ROWS: cfg.rows_used <= cfg_data[8:0];
        REG_COLS: cfg.cols_used <= cfg_data[9:0];
        REG_LAYS: cfg.layers_used <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign in_cmd = '{func: func, load_layer: load_layer, load_row: load_row,
    load_col: load_col, sample: sample, lat: lat, lon: lon};

  gbi_queue u_q (.clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .out_valid(q_valid), .out_take(q_take), .out_cmd(q_cmd));

  gbi_engine u_eng (.clk(clk), .rst(rst), .cfg(cfg), .cmd_valid(q_valid),
    .cmd_take(q_take), .cmd(q_cmd), .out_valid(out_valid), .out_stall(out_stall),
    .out_layer(layer), .out_value(value), .out_last(last), .out_status(status));
endmodule

### hdl/gbi_queue.sv
// Two-entry queue of commands between front end and back end.
// Depends on gbi_pkg.
module gbi_queue (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  gbi_pkg::cmd_t in_cmd,
  output logic out_valid,
  input  logic out_take,
  output gbi_pkg::cmd_t out_cmd
);
  import gbi_pkg::*;
  cmd_t mem [2];
  logic wp, rp;
  logic [1:0] count;
  logic push, pop;

  assign in_stall = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_cmd = mem[rp];
  assign push = in_valid && !in_stall;
  assign pop = out_valid && out_take;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_cmd;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef ASSERT_OFF
  a_no_over: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overflow");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 2'd1) else $error("count");
  a_pop: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - 2'd1) else $error("count pop");
`endif
endmodule

### hdl/gbi_divider.sv
// Iterative restoring divider, one quotient bit per cycle, unsigned.
// Depends on gbi_pkg.
module gbi_divider (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic busy,
  output logic done,
  output logic [63:0] quo
);
  import gbi_pkg::*;
  logic [63:0] rem, q, d;
  logic [6:0] cnt;
  logic [64:0] trial;

  assign trial = {rem[63:0], q[63]} - {1'b0, d};
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        rem <= '0;
        q <= num;
        d <= den;
        cnt <= 7'd64;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          q <= {q[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], q[63]};
          q <= {q[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_done: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  a_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("no start");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != 7'd0) else $error("cnt");
`endif
endmodule

### hdl/gbi_engine.sv
// Back end: loads the grid memory and runs queries with a sequencer that
// reuses one divider. Depends on gbi_pkg, gbi_divider.
module gbi_engine (
  input  logic clk,
  input  logic rst,
  input  gbi_pkg::cfg_t cfg,
  input  logic cmd_valid,
  output logic cmd_take,
  input  gbi_pkg::cmd_t cmd,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] out_layer,
  output logic signed [31:0] out_value,
  output logic out_last,
  output logic [1:0] out_status
);
  import gbi_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_RDIV = 4'd1, S_RWAIT = 4'd2,
    S_CDIV = 4'd3, S_CWAIT = 4'd4, S_CORN = 4'd5, S_FLAT = 4'd6,
    S_FLATW = 4'd7, S_FLON = 4'd8, S_FLONW = 4'd9, S_WGT = 4'd10,
    S_ACC = 4'd11, S_DIV = 4'd12, S_DIVW = 4'd13, S_EMIT = 4'd14,
    S_RD = 4'd15;
  logic [3:0] state;

  logic signed [SampleW-1:0] mem [MaxLayers*MaxRows*MaxCols];
  logic [AddrW-1:0] raddr;
  logic signed [SampleW-1:0] rdata;

  logic dstart, dbusy, ddone;
  logic [63:0] dnum, dden, dquo;
  gbi_divider u_div (.clk(clk), .rst(rst), .start(dstart), .num(dnum),
    .den(dden), .busy(dbusy), .done(ddone), .quo(dquo));

  cmd_t c;
  logic [23:0] rs, cs;
  logic [2:0] nl;
  // cell indices can reach the full coordinate span before range checks
  logic signed [25:0] r0, r2, c0, c1;
  logic signed [25:0] rows_s, cols_s;
  logic [1:0] ci;
  logic [1:0] lj;
  logic signed [25:0] cl, cc;
  logic signed [21:0] fl, fo;
  logic signed [43:0] prod;
  logic signed [61:0] lprod;
  logic signed [29:0] w;
  logic signed [31:0] sumw;
  logic signed [63:0] sums [MaxLayers];
  logic [1:0] status;
  logic neg;
  logic [32:0] rprod, cprod;
  logic signed [35:0] dlat, dlon;
  logic [63:0] qv;
  logic corner_skip, corner_out, div_go;

  assign cmd_take = (state == S_IDLE) && cmd_valid;
  assign rows_s = $signed({17'd0, cfg.rows_used});
  assign cols_s = $signed({16'd0, cfg.cols_used});
  assign cl = ci[1] ? r2 : r0;
  assign cc = ci[0] ? c1 : c0;
  // only used for corners inside the grid, so the low index bits suffice
  assign rprod = cl[RowW-1:0] * rs;
  assign cprod = cc[ColW-1:0] * cs;
  assign dlat = 36'(cfg.north_edge) - 36'(rprod) - 36'(c.lat);
  assign dlon = 36'(c.lon) - 36'(cfg.west_edge) - 36'(cprod);
  assign prod = fl * fo;
  assign lprod = rdata * w;
  assign corner_skip = (cl == -26'sd1) || (cc == -26'sd1);
  assign corner_out = cl < 0 || cl >= rows_s || cl >= 26'(MaxRows) || cc < 0 ||
                      cc >= cols_s || cc >= 26'(MaxCols);
  assign div_go = (status == ST_OK) && (sumw != 0);

  always_ff @(posedge clk) begin
    if (cmd_take && !cmd.func) mem[{cmd.load_layer, cmd.load_row, cmd.load_col}] <= cmd.sample;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      dstart <= 1'b0;
    end else begin
      dstart <= (state == S_RDIV) || (state == S_CDIV) || (state == S_FLON) ||
                (state == S_FLAT && !corner_skip && !corner_out) ||
                (state == S_DIV && div_go);
      out_valid <= (state == S_EMIT) || (out_valid && out_stall);
      case (state)
        S_IDLE: if (cmd_take && cmd.func) begin
          c <= cmd;
          rs <= (cfg.row_spacing == 24'd0) ? 24'd1 : cfg.row_spacing;
          cs <= (cfg.col_spacing == 24'd0) ? 24'd1 : cfg.col_spacing;
          nl <= (cfg.layers_used == 3'd0) ? 3'd1 :
                (cfg.layers_used > 3'(MaxLayers)) ? 3'(MaxLayers) : cfg.layers_used;
          state <= S_RDIV;
        end
        S_RDIV: begin
          dnum <= 64'(($signed(28'(cfg.north_edge) - 28'(c.lat)) < 0) ?
                   -(28'(cfg.north_edge) - 28'(c.lat)) : (28'(cfg.north_edge) - 28'(c.lat)));
          neg <= ($signed(28'(cfg.north_edge) - 28'(c.lat)) < 0);
          dden <= 64'(rs);
          state <= S_RWAIT;
        end
        S_RWAIT: if (ddone) begin
          r0 <= neg ? -26'(dquo) : 26'(dquo);
          state <= S_CDIV;
        end
        S_CDIV: begin
          dnum <= 64'(($signed(28'(c.lon) - 28'(cfg.west_edge)) < 0) ?
                   -(28'(c.lon) - 28'(cfg.west_edge)) : (28'(c.lon) - 28'(cfg.west_edge)));
          neg <= ($signed(28'(c.lon) - 28'(cfg.west_edge)) < 0);
          dden <= 64'(cs);
          state <= S_CWAIT;
        end
        S_CWAIT: if (ddone) begin
          c0 <= neg ? -26'(dquo) : 26'(dquo);
          state <= S_CORN;
        end
        S_CORN: begin
          if (r0 + 26'sd1 >= rows_s) begin
            r2 <= rows_s - 26'sd1;
            if (r0 > 0) r0 <= r0 - 26'sd1;
          end else r2 <= r0 + 26'sd1;
          if (c0 + 26'sd1 >= cols_s) begin
            c1 <= cols_s - 26'sd1;
            if (c0 > 0) c0 <= c0 - 26'sd1;
          end else c1 <= c0 + 26'sd1;
          ci <= 2'd0;
          lj <= 2'd0;
          sumw <= '0;
          status <= ST_OK;
          for (int j = 0; j < MaxLayers; j++) sums[j] <= '0;
          state <= S_FLAT;
        end
        S_FLAT: begin
          if (corner_skip) begin
            ci <= ci + 2'd1;
            state <= (ci == 2'd3) ? S_DIV : S_FLAT;
          end else if (corner_out) begin
            status <= ST_OUT;
            ci <= ci + 2'd1;
            state <= (ci == 2'd3) ? S_DIV : S_FLAT;
          end else begin
            dnum <= 64'(dlat < 0 ? -dlat : dlat) << 16;
            dden <= 64'(rs);
            state <= S_FLATW;
          end
        end
        S_FLATW: if (ddone) begin
          fl <= 22'(QOne) - ((dquo > 64'(QMax)) ? 22'(QMax) : 22'(dquo));
          state <= S_FLON;
        end
        S_FLON: begin
          dnum <= 64'(dlon < 0 ? -dlon : dlon) << 16;
          dden <= 64'(cs);
          state <= S_FLONW;
        end
        S_FLONW: if (ddone) begin
          fo <= 22'(QOne) - ((dquo > 64'(QMax)) ? 22'(QMax) : 22'(dquo));
          state <= S_WGT;
        end
        S_WGT: begin
          w <= (prod >= 0) ? 30'(prod >>> 16) : -30'((-prod + 44'sd65535) >>> 16);
          lj <= 2'd0;
          raddr <= {2'd0, cl[RowW-1:0], cc[ColW-1:0]};
          state <= S_RD;
        end
        S_RD: begin
          // the corner weight counts once, not once per layer
          if (lj == 2'd0) sumw <= sumw + 32'(w);
          state <= S_ACC;
          raddr <= {lj + 2'd1, cl[RowW-1:0], cc[ColW-1:0]};
        end
        S_ACC: begin
          sums[lj] <= sums[lj] + 64'(lprod);
          if ({1'b0, lj} + 3'd1 >= nl) begin
            ci <= ci + 2'd1;
            lj <= 2'd0;
            state <= (ci == 2'd3) ? S_DIV : S_FLAT;
          end else begin
            lj <= lj + 2'd1;
            raddr <= {lj + 2'd1, cl[RowW-1:0], cc[ColW-1:0]};
            state <= S_RD;
          end
        end
        S_DIV: begin
          if (status == ST_OK && sumw == 0) status <= ST_ZERO;
          if (!div_go) begin
            qv <= '0;
            state <= S_EMIT;
          end else begin
            dnum <= 2 * 64'(sums[lj] < 0 ? -sums[lj] : sums[lj]) +
                    64'(sumw < 0 ? -sumw : sumw);
            dden <= 2 * 64'(sumw < 0 ? -sumw : sumw);
            neg <= (sums[lj] < 0) != (sumw < 0);
            state <= S_DIVW;
          end
        end
        S_DIVW: if (ddone) begin
          if (neg) qv <= (dquo > 64'h8000_0000) ? 64'h8000_0000 : dquo;
          else qv <= (dquo > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : dquo;
          state <= S_EMIT;
        end
        S_EMIT: if (!out_valid || !out_stall) begin
          out_layer <= lj;
          out_value <= (status != ST_OK) ? 32'sd0 : (neg ? -32'(qv) : 32'(qv));
          out_last <= ({1'b0, lj} + 3'd1 == nl);
          out_status <= status;
          if ({1'b0, lj} + 3'd1 == nl) state <= S_IDLE;
          else begin
            lj <= lj + 2'd1;
            state <= S_DIV;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_take: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> state == S_IDLE) else $error("take while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("dropped result");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_OK) |-> out_value == 32'sd0) else $error("val");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    dstart |-> !dbusy) else $error("divider started while busy");
`endif
endmodule

### dv/grid_bilinear_interpolator_tb.sv
// Testbench for grid_bilinear_interpolator: random load and query traffic
// checked against a built-in bilinear predictor. Depends on gbi_pkg.
module grid_bilinear_interpolator_tb;
  import gbi_pkg::*;

  localparam logic [2:0] RegNone = 3'd7;  // index past the register list
  localparam int CycleLimit = 2000000;
  localparam longint LatMax = 5898240;
  localparam longint LonMax = 11796480;

  typedef struct {
    logic [1:0] layer;
    logic [31:0] value;
    logic last;
    logic [1:0] status;
  } interp_t;

  class grid_scoreboard;
    int grid_mem[int];
    longint north, west, rsp, csp, rows, cols, lays;
    interp_t pending_q[$];
    int mismatches;

    function new();
      north = 5898240;
      west = -11796480;
      rsp = 65536;
      csp = 65536;
      rows = 181;
      cols = 360;
      lays = 4;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        REG_NORTH: north = longint'(signed'(d[23:0]));
        REG_WEST: west = longint'(signed'(d[24:0]));
        REG_RSP: rsp = longint'(d[23:0]);
        REG_CSP: csp = longint'(d[23:0]);
        REG_ROWS: rows = longint'(d[8:0]);
        REG_COLS: cols = longint'(d[9:0]);
        REG_LAYS: lays = longint'(d[2:0]);
        default: ;
      endcase
    endfunction

    function int cell_key(longint ly, longint r, longint c);
      return int'((ly * MaxRows + r) * MaxCols + c);
    endfunction

    // Four corners in the order (r0,c0) (r0,c1) (r2,c0) (r2,c1)
    function void corners(longint lat, longint lon, output longint cr[4],
                          output longint cc[4]);
      longint rs, cs, r0, r2, c0, c1;
      rs = (rsp == 0) ? 1 : rsp;
      cs = (csp == 0) ? 1 : csp;
      r0 = (north - lat) / rs;
      r2 = r0 + 1;
      if (r2 >= rows) begin
        r2 = rows - 1;
        if (r0 > 0) r0--;
      end
      c0 = (lon - west) / cs;
      c1 = c0 + 1;
      if (c1 >= cols) begin
        c1 = cols - 1;
        if (c0 > 0) c0--;
      end
      cr = '{r0, r0, r2, r2};
      cc = '{c0, c1, c0, c1};
    endfunction

    function bit in_grid(longint r, longint c);
      return r >= 0 && r < rows && r < MaxRows && c >= 0 && c < cols && c < MaxCols;
    endfunction

    function longint axis_weight(longint d, longint sp);
      longint a, q;
      a = (d < 0) ? -d : d;
      q = (a << 16) / sp;
      if (q > QMax) q = QMax;
      return QOne - q;
    endfunction

    // Rounded to nearest, ties away from zero, clamped to 32 bits signed
    function longint round_quot(longint num, longint den);
      longint an, ad, q;
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      q = (2 * an + ad) / (2 * ad);
      if ((num < 0) != (den < 0)) begin
        if (q > 64'sd2147483648) q = 64'sd2147483648;
        return -q;
      end
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      return q;
    endfunction

    function void note_input(cmd_t c);
      longint lat, lon, rs, cs, nl, sumw, p, w, dlat, dlon;
      longint cr[4], cc[4];
      longint sums[MaxLayers];
      logic [1:0] st;
      interp_t r;
      if (!c.func) begin
        grid_mem[cell_key(c.load_layer, c.load_row, c.load_col)] = c.sample;
        return;
      end
      lat = longint'(signed'(c.lat));
      lon = longint'(signed'(c.lon));
      rs = (rsp == 0) ? 1 : rsp;
      cs = (csp == 0) ? 1 : csp;
      nl = (lays < 1) ? 1 : ((lays > MaxLayers) ? MaxLayers : lays);
      corners(lat, lon, cr, cc);
      sumw = 0;
      st = ST_OK;
      foreach (sums[j]) sums[j] = 0;
      for (int i = 0; i < 4; i++) begin
        if (cr[i] == -1 || cc[i] == -1) continue;
        if (!in_grid(cr[i], cc[i])) begin
          st = ST_OUT;
          continue;
        end
        dlat = north - cr[i] * rs - lat;
        dlon = lon - (west + cc[i] * cs);
        p = axis_weight(dlat, rs) * axis_weight(dlon, cs);
        w = (p >= 0) ? (p >>> 16) : -((-p + 65535) >>> 16);
        sumw += w;
        for (int j = 0; j < nl; j++)
          sums[j] += longint'(grid_mem[cell_key(j, cr[i], cc[i])]) * w;
      end
      if (st == ST_OK && sumw == 0) st = ST_ZERO;
      for (int j = 0; j < nl; j++) begin
        r.layer = j[1:0];
        r.value = (st != ST_OK) ? 32'd0 : 32'(round_quot(sums[j], sumw));
        r.last = (j == nl - 1);
        r.status = st;
        pending_q.push_back(r);
      end
    endfunction

    function void check_result(logic [1:0] ly, logic [31:0] v, logic lst,
                               logic [1:0] st);
      interp_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: layer %0d value %h last %b status %0d",
                   ly, v, lst, st);
        return;
      end
      e = pending_q.pop_front();
      if (e.layer !== ly || e.value !== v || e.last !== lst || e.status !== st) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp layer %0d value %h last %b status %0d, got %0d %h %b %0d",
                   e.layer, e.value, e.last, e.status, ly, v, lst, st);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_stall, func;
  logic [1:0] load_layer;
  logic [7:0] load_row;
  logic [8:0] load_col;
  logic signed [31:0] sample;
  logic signed [23:0] lat;
  logic signed [24:0] lon;
  logic out_valid, out_stall, last;
  logic [1:0] layer, status;
  logic signed [31:0] value;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  grid_scoreboard sb;
  bit calm;
  int items_sent;
  int cycles;

  grid_bilinear_interpolator u_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall) sb.check_result(layer, value, last, status);

  always @(negedge clk)
    out_stall <= !calm && ($urandom_range(0, 99) < 10);

  // Entered and left at a falling edge; valid stays up between back-to-back items
  task automatic send(cmd_t c);
    while (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= c.func;
    load_layer <= c.load_layer;
    load_row <= c.load_row;
    load_col <= c.load_col;
    sample <= c.sample;
    lat <= c.lat;
    lon <= c.lon;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(c);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return {16'($urandom_range(0, 200) - 100), 16'h0};
    endcase
  endfunction

  task automatic load(logic [1:0] ly, logic [7:0] r, logic [8:0] c, logic [31:0] s);
    cmd_t cmd;
    cmd = '0;
    cmd.load_layer = ly;
    cmd.load_row = r;
    cmd.load_col = c;
    cmd.sample = s;
    send(cmd);
  endtask

  // Loads every in-grid corner not yet written, then issues the query
  task automatic query(longint qlat, longint qlon);
    longint cr[4], cc[4];
    cmd_t cmd;
    sb.corners(qlat, qlon, cr, cc);
    for (int i = 0; i < 4; i++)
      if (sb.in_grid(cr[i], cc[i]))
        for (int j = 0; j < MaxLayers; j++)
          if (!sb.grid_mem.exists(sb.cell_key(j, cr[i], cc[i])))
            load(j[1:0], cr[i][7:0], cc[i][8:0], pick_sample());
    cmd = '0;
    cmd.func = 1'b1;
    cmd.lat = qlat[23:0];
    cmd.lon = qlon[24:0];
    cmd.load_layer = 2'($urandom);
    cmd.sample = $urandom;
    send(cmd);
  endtask

  function automatic longint clip(longint v, longint lim);
    return (v > lim) ? lim : ((v < -lim) ? -lim : v);
  endfunction

  task automatic run_traffic(int target);
    longint rs, cs, span, qlat, qlon;
    int pick;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      rs = (sb.rsp == 0) ? 1 : sb.rsp;
      cs = (sb.csp == 0) ? 1 : sb.csp;
      if (pick < 10) begin
        load(2'($urandom), 8'($urandom), 9'($urandom), pick_sample());
      end else if (pick < 22) begin
        query(longint'($urandom_range(0, 2 * LatMax)) - LatMax,
              longint'($urandom_range(0, 2 * LonMax)) - LonMax);
      end else begin
        // near the grid, reaching one cell past each edge
        span = (sb.rows + 2) * rs;
        if (span > 2 * LatMax) span = 2 * LatMax;
        qlat = clip(sb.north + rs - longint'($urandom_range(0, span)), LatMax);
        span = (sb.cols + 2) * cs;
        if (span > 2 * LonMax) span = 2 * LonMax;
        qlon = clip(sb.west - cs + longint'($urandom_range(0, span)), LonMax);
        query(qlat, qlon);
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic set_grid(longint n, longint w, longint rs, longint cs, int r, int c,
                          int ly);
    write_cfg(REG_NORTH, 32'(n));
    write_cfg(REG_WEST, 32'(w));
    write_cfg(REG_RSP, 32'(rs));
    write_cfg(REG_CSP, 32'(cs));
    write_cfg(REG_ROWS, 32'(r));
    write_cfg(REG_COLS, 32'(c));
    write_cfg(REG_LAYS, 32'(ly));
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    func = 1'b0;
    load_layer = '0;
    load_row = '0;
    load_col = '0;
    sample = '0;
    lat = '0;
    lon = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, default grid: extreme samples and corners of the globe
    load(2'd3, 8'd255, 9'd511, 32'h7fffffff);
    load(2'd0, 8'd0, 9'd0, 32'h80000000);
    query(LatMax, -LonMax);
    query(-LatMax, LonMax);
    query(0, 0);
    query(LatMax, LonMax);
    query(32768, 32768);
    run_traffic(100);
    calm = 1'b0;
    run_traffic(150);
    settle();

    set_grid(LatMax, -LonMax, 65536, 65536, 4, 5, 1);
    run_traffic(210);
    settle();
    set_grid(100000, 0, 1, 1, 256, 512, 4);
    run_traffic(270);
    settle();
    set_grid(LatMax, -LonMax, 11796480, 11796480, 2, 2, 3);
    run_traffic(330);
    settle();
    // zero spacing and a zero layer count, plus a write past the register list
    set_grid(-LatMax, LonMax, 0, 0, 1, 1, 0);
    write_cfg(RegNone, $urandom);
    run_traffic(400);
    settle();
    set_grid(0, 0, 655360, 3000, 3, 3, 7);
    run_traffic(480);
    settle();

    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
